// ===== hdl/pse_pkg.sv =====
// Package with widths, command and status codes for the prime sieve engine.
`timescale 1ns / 1ps

package pse_pkg;

  localparam int LIMIT_W  = 12;
  localparam int NUMBER_W = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  // The sieve root never passes 64 and its square never passes 4096 for a 12-bit limit.
  localparam int ROOT_W   = 7;
  localparam int SQ_W     = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd25;

  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUN = 2'd2;

  localparam logic MARK_COMPOSITE = 1'b1;

endpackage

// ===== hdl/pse_if.sv =====
// Channel interfaces for commands, results and the limit register write.
`timescale 1ns / 1ps

interface pse_req_if
  import pse_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                command;
  logic [NUMBER_W-1:0] number;

  modport source (output valid, output command, output number, input ready);
  modport sink   (input valid, input command, input number, output ready);
endinterface

interface pse_rsp_if
  import pse_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                is_prime;
  logic [COUNT_W-1:0]  prime_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output is_prime, output prime_count, output status,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_count, input status,
                  output ready);
endinterface

interface pse_cfg_if
  import pse_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pse_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pse_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/prime_sieve_engine.sv =====
// Top level of the prime sieve engine: command sequencer around the bitmap memory.
`timescale 1ns / 1ps

//  channel  direction  payload                          transfer when
//  req      in         command, number                  req.valid & req.ready
//  rsp      out        is_prime, prime_count, status    rsp.valid & rsp.ready
//  cfg      in         data (limit register)            cfg.valid & cfg.ready
//
// A query reads the bitmap memory once, then loads the result register.
// A run clears the bitmap up to the effective limit, marks the composites and then
// counts the primes, each step in turn through the bitmap memory.
// Reset is synchronous; no clearing pass follows it, since queries read the bitmap
// only after a run has cleared it. A stalled result holds the sequencer in place.

module prime_sieve_engine
  import pse_pkg::*;
#(
  parameter int MAX_NUMBERS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  pse_req_if.sink       req,
  pse_rsp_if.source     rsp,
  pse_cfg_if.sink       cfg
);

  localparam int AW      = $clog2(MAX_NUMBERS);
  localparam int TOP_INT = (MAX_NUMBERS - 1 > 4095) ? 4095 : MAX_NUMBERS - 1;
  localparam logic [LIMIT_W-1:0] LIM_TOP = LIMIT_W'(TOP_INT);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_TEST  = 9'b000001000,
    S_MARK  = 9'b000010000,
    S_COUNT = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_RESP  = 9'b010000000,
    S_QRESP = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [LIMIT_W-1:0]  limit;
  logic                sieve_valid;
  logic [LIMIT_W-1:0]  eff_lim;
  logic [LIMIT_W-1:0]  idx;
  logic [ROOT_W-1:0]   p;
  logic [SQ_W-1:0]     psq;
  logic [SQ_W-1:0]     m;
  logic [COUNT_W-1:0]  count;
  logic                rd_pend;
  logic [STATUS_W-1:0] q_status;
  logic [STATUS_W-1:0] q_status_next;

  logic                out_valid;
  logic                out_is_prime;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;
  logic                out_free;
  logic                out_load;

  logic                req_xfer, cfg_xfer;
  logic                idx_last, root_done, mark_done;
  logic [SQ_W-1:0]     psq_adv;

  logic                ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0]       ram_waddr, ram_raddr;

  assign eff_lim   = (limit > LIM_TOP) ? LIM_TOP : limit;
  assign req_xfer  = req.valid && req.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = out_free && ((state == S_RESP) || (state == S_QRESP));
  assign idx_last  = (idx == eff_lim);
  assign root_done = (psq > SQ_W'(eff_lim));
  assign mark_done = ((SQ_W + 1)'(m) + (SQ_W + 1)'(p)) > (SQ_W + 1)'(eff_lim);
  // Next square from the current one: (p+1)^2 = p^2 + 2p + 1.
  assign psq_adv   = psq + (SQ_W'(p) << 1) + SQ_W'(1);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.is_prime    = out_is_prime;
  assign rsp.prime_count = out_count;
  assign rsp.status      = out_status;

  always_comb begin
    if (!sieve_valid) begin
      q_status_next = STATUS_NO_RUN;
    end else if (req.number > eff_lim) begin
      q_status_next = STATUS_RANGE;
    end else begin
      q_status_next = STATUS_OK;
    end
  end

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_waddr = AW'(idx);
    ram_re    = 1'b0;
    ram_raddr = AW'(idx);
    case (state)
      S_IDLE: begin
        ram_re    = req_xfer && (req.command == CMD_QUERY) && (q_status_next == STATUS_OK);
        ram_raddr = AW'(req.number);
      end
      S_CLEAR: begin
        // Entries 0 and 1 are marked composite as the bitmap is cleared.
        ram_we    = 1'b1;
        ram_wdata = (idx < LIMIT_W'(2)) ? MARK_COMPOSITE : 1'b0;
      end
      S_CHECK: begin
        ram_re    = !root_done;
        ram_raddr = AW'(p);
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = MARK_COMPOSITE;
        ram_waddr = AW'(m);
      end
      S_COUNT: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          state_next = (req.command == CMD_RUN) ? S_CLEAR : S_QRESP;
        end
      end
      S_CLEAR: if (idx_last) state_next = S_CHECK;
      S_CHECK: state_next = root_done ? S_COUNT : S_TEST;
      S_TEST:  state_next = ram_rdata ? S_CHECK : S_MARK;
      S_MARK:  if (mark_done) state_next = S_CHECK;
      S_COUNT: if (idx_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      S_QRESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      limit       <= LIMIT_RESET;
      sieve_valid <= 1'b0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_xfer) begin
        limit       <= cfg.data;
        sieve_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          idx      <= '0;
          q_status <= q_status_next;
        end
        S_CLEAR: begin
          idx <= idx + LIMIT_W'(1);
          p   <= ROOT_W'(2);
          psq <= SQ_W'(4);
        end
        S_CHECK: begin
          idx     <= '0;
          count   <= '0;
          rd_pend <= 1'b0;
          m       <= psq;
        end
        S_TEST: begin
          if (ram_rdata) begin
            p   <= p + ROOT_W'(1);
            psq <= psq_adv;
          end
        end
        S_MARK: begin
          m <= m + SQ_W'(p);
          if (mark_done) begin
            p   <= p + ROOT_W'(1);
            psq <= psq_adv;
          end
        end
        S_COUNT: begin
          idx     <= idx + LIMIT_W'(1);
          rd_pend <= 1'b1;
          if (rd_pend && !ram_rdata) begin
            count <= count + COUNT_W'(1);
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          if (rd_pend && !ram_rdata) begin
            count <= count + COUNT_W'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_is_prime <= 1'b0;
            out_count    <= count;
            out_status   <= STATUS_OK;
            sieve_valid  <= 1'b1;
          end
        end
        S_QRESP: begin
          if (out_free) begin
            out_is_prime <= (q_status == STATUS_OK) && !ram_rdata;
            out_count    <= '0;
            out_status   <= q_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

  pse_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBERS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A limit write invalidates the bitmap.
  assert property (@(posedge clk) disable iff (rst)
    cfg_xfer |=> !sieve_valid)
    else $error("bitmap still valid after a limit write");

  // The incremental square tracks the current sieve root.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (psq == SQ_W'(14'(p) * 14'(p))))
    else $error("root square out of step with root");

  // Composite marks stay inside the covered range.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (m <= SQ_W'(eff_lim)) && (m >= SQ_W'(4)))
    else $error("composite mark outside the covered range");

  // A prime flag only comes with a clean query result.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_is_prime) |-> (out_status == STATUS_OK) && (out_count == '0))
    else $error("prime flag on a result that is not a clean query");

endmodule

// ===== tb/pse_answer_check.sv =====
// Checker for the prime sieve engine: predicts every answer and compares it field by field.
`timescale 1ns / 1ps

module pse_answer_check
  import pse_pkg::*;
#(
  parameter int MAX_NUMBERS = 4096
) (
  input  logic clk,
  input  logic rst,
  pse_req_if   req,
  pse_rsp_if   rsp,
  pse_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   run_count,
  output int   in_range_queries,
  output int   above_limit_queries,
  output int   early_queries
);

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic                is_prime;
    logic [COUNT_W-1:0]  prime_count;
    logic [STATUS_W-1:0] status;
  } answer_t;

  answer_t            answer_fifo[$];
  bit                 composite_bits[MAX_NUMBERS];
  logic [LIMIT_W-1:0] limit_reg;
  int unsigned        sieved_limit;
  bit                 sieve_done;

  // Rebuilds the composite bitmap over 0..top (clipped to MAX_NUMBERS-1) and returns how many primes it holds.
  function automatic int unsigned sieve_upto(input int unsigned top);
    int unsigned lim;
    int unsigned cnt;
    lim = (top > MAX_NUMBERS - 1) ? MAX_NUMBERS - 1 : top;
    cnt = 0;
    foreach (composite_bits[i]) composite_bits[i] = 1'b0;
    composite_bits[0] = MARK_COMPOSITE;
    composite_bits[1] = MARK_COMPOSITE;
    for (int unsigned p = 2; p * p <= lim; p++) begin
      if (!composite_bits[p]) begin
        for (int unsigned m = p * p; m <= lim; m += p) composite_bits[m] = MARK_COMPOSITE;
      end
    end
    for (int unsigned i = 0; i <= lim; i++) begin
      if (!composite_bits[i]) cnt++;
    end
    return cnt;
  endfunction

  always @(posedge clk) begin : watch
    answer_t     want;
    answer_t     got;
    int unsigned cnt;
    if (rst) begin
      answer_fifo.delete();
      limit_reg           = LIMIT_RESET;
      sieved_limit        = 0;
      sieve_done          = 1'b0;
      fail_count          = 0;
      run_count           = 0;
      in_range_queries    = 0;
      above_limit_queries = 0;
      early_queries       = 0;
    end else begin
      // Any limit write invalidates the bitmap until the next run.
      if (cfg.valid && cfg.ready) begin
        limit_reg  = cfg.data;
        sieve_done = 1'b0;
      end

      // Results are matched before new requests are queued.
      if (rsp.valid && rsp.ready) begin
        got.is_prime    = rsp.is_prime;
        got.prime_count = rsp.prime_count;
        got.status      = rsp.status;
        if (answer_fifo.size() == 0) begin
          $error("result transfer with no request outstanding: is_prime %0d count %0d status %0d",
                 got.is_prime, got.prime_count, got.status);
          fail_count++;
        end else begin
          want = answer_fifo.pop_front();
          if (got.is_prime !== want.is_prime) begin
            $error("is_prime: expected %0d, actual %0d", want.is_prime, got.is_prime);
            fail_count++;
          end
          if (got.prime_count !== want.prime_count) begin
            $error("prime_count: expected %0d, actual %0d", want.prime_count, got.prime_count);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
        end
      end

      if (req.valid && req.ready) begin
        want        = '0;
        want.status = STATUS_OK;
        if (req.command == CMD_RUN) begin
          cnt              = sieve_upto(limit_reg);
          want.prime_count = COUNT_W'((cnt > COUNT_MAX) ? COUNT_MAX : cnt);
          sieved_limit     = (limit_reg > MAX_NUMBERS - 1) ? MAX_NUMBERS - 1 : limit_reg;
          sieve_done       = 1'b1;
          run_count++;
        end else if (!sieve_done) begin
          want.status = STATUS_NO_RUN;
          early_queries++;
        end else if (req.number > sieved_limit) begin
          want.status = STATUS_RANGE;
          above_limit_queries++;
        end else begin
          want.is_prime = !composite_bits[req.number];
          in_range_queries++;
        end
        answer_fifo.push_back(want);
      end
    end
    pending = answer_fifo.size();
  end

endmodule

// ===== tb/tb_prime_sieve_engine.sv =====
// Testbench top for the prime sieve engine: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_prime_sieve_engine;
  import pse_pkg::*;

  localparam int MAX_NUMBERS = 4096;
  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int BIG_PHASES  = 5;

  logic clk;
  logic rst;

  pse_req_if req ();
  pse_rsp_if rsp ();
  pse_cfg_if cfg ();

  int fail_count;
  int pending;
  int run_count;
  int in_range_queries;
  int above_limit_queries;
  int early_queries;
  int cycle_count;
  int items_sent;
  int burst_left;
  int cfg_writes;
  int big_phases;

  prime_sieve_engine #(
    .MAX_NUMBERS(MAX_NUMBERS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  pse_answer_check #(
    .MAX_NUMBERS(MAX_NUMBERS)
  ) answer_check (
    .clk                (clk),
    .rst                (rst),
    .req                (req),
    .rsp                (rsp),
    .cfg                (cfg),
    .fail_count         (fail_count),
    .pending            (pending),
    .run_count          (run_count),
    .in_range_queries   (in_range_queries),
    .above_limit_queries(above_limit_queries),
    .early_queries      (early_queries)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("tb_prime_sieve_engine NOT OK");
    $finish;
  end

  // The result side stalls in modes that are picked at random.
  initial begin : result_stalls
    int mode;
    int hold;
    int mode_left;
    rsp.ready = 1'b0;
    mode      = 0;
    hold      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = 150;
        hold      = 0;
      end
      mode_left--;
      case (mode)
        0: begin
          rsp.ready = 1'b1;
        end
        1: begin
          rsp.ready = ($urandom_range(0, 9) < 6);
        end
        2: begin
          rsp.ready = (mode_left % 4 == 0);
        end
        default: begin
          if (hold == 0) begin
            rsp.ready = ~rsp.ready;
            hold      = rsp.ready ? $urandom_range(1, 5) : $urandom_range(5, 20);
          end
          hold--;
        end
      endcase
    end
  end

  // Entered and left at a falling edge; valid stays high between items of one burst.
  task automatic send_item(input logic cmd, input logic [NUMBER_W-1:0] num);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
    end
    req.valid   = 1'b1;
    req.command = cmd;
    req.number  = num;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg.valid = 1'b1;
    cfg.data  = value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
    cfg_writes++;
  endtask

  // Waits until every answer has come back, then lets the sequencer settle.
  task automatic settle();
    req.valid  = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [NUMBER_W-1:0] pick_number(input logic [LIMIT_W-1:0] lim);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return NUMBER_W'($urandom_range(0, lim));
    if (sel < 85 && lim < 4095) return NUMBER_W'($urandom_range(lim + 1, 4095));
    return NUMBER_W'($urandom_range(0, 4095));
  endfunction

  initial begin : stimulus
    logic [NUMBER_W-1:0] probes[10];
    logic [LIMIT_W-1:0]  lim;
    int                  sel;
    bit                  big;
    probes      = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd23, 12'd24, 12'd25, 12'd26, 12'd4095};
    items_sent  = 0;
    burst_left  = 0;
    cfg_writes  = 0;
    big_phases  = 0;
    req.valid   = 1'b0;
    req.command = CMD_RUN;
    req.number  = '0;
    cfg.valid   = 1'b0;
    cfg.data    = '0;
    rst         = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on the reset limit: a query before any run, then a run and edge probes.
    send_item(CMD_QUERY, 12'd5);
    send_item(CMD_RUN, 12'd0);
    foreach (probes[i]) send_item(CMD_QUERY, probes[i]);

    // Largest limit; the write must invalidate the earlier run.
    settle();
    write_limit(12'd4095);
    send_item(CMD_QUERY, 12'd7);
    send_item(CMD_RUN, 12'hFFF);
    send_item(CMD_QUERY, 12'd4093);
    send_item(CMD_QUERY, 12'd4094);
    send_item(CMD_QUERY, 12'd4095);
    send_item(CMD_QUERY, 12'd2048);

    // Limits of zero and one count no primes; a limit of two follows.
    settle();
    write_limit(12'd0);
    send_item(CMD_RUN, 12'd0);
    send_item(CMD_QUERY, 12'd0);
    send_item(CMD_QUERY, 12'd1);
    settle();
    write_limit(12'd1);
    send_item(CMD_RUN, 12'd0);
    send_item(CMD_QUERY, 12'd1);
    settle();
    write_limit(12'd2);
    send_item(CMD_RUN, 12'd0);
    send_item(CMD_QUERY, 12'd2);
    send_item(CMD_QUERY, 12'd3);
    lim = 12'd2;
    big = 1'b0;

    // Random phases: usually a limit write and a run, then mostly queries with random content.
    while (items_sent < ITEM_TARGET) begin
      settle();
      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          lim = LIMIT_W'($urandom_range(0, 3));
        end else if (sel < 10 && big_phases < BIG_PHASES) begin
          lim = (sel < 7) ? 12'd4095 : LIMIT_W'($urandom_range(1024, 4094));
          big_phases++;
        end else begin
          lim = LIMIT_W'($urandom_range(2, 300));
        end
        big = (lim > 1023);
        write_limit(lim);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(CMD_QUERY, NUMBER_W'($urandom_range(0, 4095)));
          end
        end
        send_item(CMD_RUN, NUMBER_W'($urandom_range(0, 4095)));
      end
      repeat ($urandom_range(10, 40)) begin
        if (!big && $urandom_range(0, 19) == 0) begin
          send_item(CMD_RUN, NUMBER_W'($urandom_range(0, 4095)));
        end else begin
          send_item(CMD_QUERY, pick_number(lim));
        end
      end
    end

    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d sieve runs across %0d limit writes and %0d requests in all.",
             run_count, cfg_writes, items_sent);
    $display("Queries: %0d within the limit, %0d above it, %0d before a valid run.",
             in_range_queries, above_limit_queries, early_queries);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_prime_sieve_engine OK");
    end else begin
      $display("tb_prime_sieve_engine NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pse_pkg.sv
hdl/pse_if.sv
hdl/pse_ram.sv
hdl/prime_sieve_engine.sv
tb/pse_answer_check.sv
tb/tb_prime_sieve_engine.sv
